FILE: hw/rtl/bce_pkg.sv
// Shared types and constants for the Bernstein curve evaluation unit.
// Used by every module of the block; depends on nothing.
package bce_pkg;

    localparam int FRAC_BITS    = 15;
    localparam int COORD_WIDTH  = 16;
    localparam int T_WIDTH      = 16;
    localparam int WEIGHT_WIDTH = 20;
    localparam int VALUE_WIDTH  = 21;
    localparam int NUM_LANES    = 4;
    localparam int MODE_WIDTH   = 3;

    localparam int PROD_WIDTH = WEIGHT_WIDTH + COORD_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + 2;
    localparam int ONE_Q      = 1 << FRAC_BITS;
    localparam int HALF_Q     = 1 << (FRAC_BITS - 1);

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_LINEAR = 3'd0,
        MODE_QUAD   = 3'd1,
        MODE_CUBIC  = 3'd2,
        MODE_DERIV1 = 3'd3,
        MODE_DERIV2 = 3'd4
    } mode_t;

    typedef logic signed [COORD_WIDTH-1:0]  coord_t;
    typedef logic signed [WEIGHT_WIDTH-1:0] weight_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;

    typedef coord_t  [NUM_LANES-1:0] coord_vec_t;
    typedef weight_t [NUM_LANES-1:0] weight_vec_t;
    typedef prod_t   [NUM_LANES-1:0] prod_vec_t;

    typedef struct packed {
        logic [MODE_WIDTH-1:0] req_type;
        logic [T_WIDTH-1:0]    t_param;
        coord_t                coord0;
        coord_t                coord1;
        coord_t                coord2;
        coord_t                coord3;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] curve_value;
        weight_t                       weight0;
        weight_t                       weight1;
        weight_t                       weight2;
        weight_t                       weight3;
    } rsp_t;

    // stage enables for the basis pipeline, plus valid of its last stage
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic v3;
    } basis_ctl_t;

endpackage

FILE: hw/rtl/bce_basis.sv
// Basis weight generator: three pipeline stages from t and mode to the four weights.
// Carries the control coordinates alongside. Depends on bce_pkg.
module bce_basis (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bce_pkg::basis_ctl_t   ctl,
    input  bce_pkg::req_t         req,
    output bce_pkg::weight_vec_t  weights,
    output bce_pkg::coord_vec_t   coords
);

    localparam int Q_WIDTH = bce_pkg::FRAC_BITS + 1;
    localparam int P_WIDTH = 2 * Q_WIDTH + 2;
    localparam int WX      = bce_pkg::WEIGHT_WIDTH + 2;

    localparam logic signed [WX-1:0] K3S  = WX'(3 * bce_pkg::ONE_Q);
    localparam logic signed [WX-1:0] K6S  = WX'(6 * bce_pkg::ONE_Q);
    localparam logic signed [WX-1:0] K12S = WX'(12 * bce_pkg::ONE_Q);

    // (x + half) >> FRAC_BITS for non-negative x
    function automatic logic [Q_WIDTH-1:0] rnd_q(input logic [P_WIDTH-1:0] x);
        logic [P_WIDTH:0] s;
        s = {1'b0, x} + (P_WIDTH + 1)'(bce_pkg::HALF_Q);
        return s[bce_pkg::FRAC_BITS +: Q_WIDTH];
    endfunction

    function automatic logic signed [WX-1:0] sx(input logic [Q_WIDTH-1:0] v);
        return signed'(WX'(v));
    endfunction

    // stage 1: saturate t, squares and cross product
    logic [Q_WIDTH-1:0]   t_sat;
    logic [Q_WIDTH-1:0]   u_sat;
    logic [2*Q_WIDTH-1:0] tt_next;
    logic [2*Q_WIDTH-1:0] uu_next;
    logic [2*Q_WIDTH-1:0] tu_next;

    logic [bce_pkg::MODE_WIDTH-1:0] mode1_reg;
    logic [Q_WIDTH-1:0]             t1_reg;
    logic [Q_WIDTH-1:0]             u1_reg;
    logic [2*Q_WIDTH-1:0]           tt1_reg;
    logic [2*Q_WIDTH-1:0]           uu1_reg;
    logic [2*Q_WIDTH-1:0]           tu1_reg;
    bce_pkg::coord_vec_t            coords1_reg;

    assign t_sat   = (req.t_param > bce_pkg::T_WIDTH'(bce_pkg::ONE_Q))
                   ? Q_WIDTH'(bce_pkg::ONE_Q) : Q_WIDTH'(req.t_param);
    assign u_sat   = Q_WIDTH'(bce_pkg::ONE_Q) - t_sat;
    assign tt_next = (2*Q_WIDTH)'(t_sat) * (2*Q_WIDTH)'(t_sat);
    assign uu_next = (2*Q_WIDTH)'(u_sat) * (2*Q_WIDTH)'(u_sat);
    assign tu_next = (2*Q_WIDTH)'(t_sat) * (2*Q_WIDTH)'(u_sat);

    // stage 2: rounded squares, cubic products
    logic [Q_WIDTH-1:0]   tq;
    logic [Q_WIDTH-1:0]   uq;
    logic [Q_WIDTH-1:0]   w1q;
    logic [Q_WIDTH+1:0]   tri_u2;
    logic [Q_WIDTH+1:0]   tri_t2;
    logic [P_WIDTH-1:0]   p_u3_next;
    logic [P_WIDTH-1:0]   p_w1_next;
    logic [P_WIDTH-1:0]   p_w2_next;
    logic [P_WIDTH-1:0]   p_t3_next;

    logic [bce_pkg::MODE_WIDTH-1:0] mode2_reg;
    logic [Q_WIDTH-1:0]             t2_reg;
    logic [Q_WIDTH-1:0]             u2_reg;
    logic [Q_WIDTH-1:0]             tq2_reg;
    logic [Q_WIDTH-1:0]             uq2_reg;
    logic [Q_WIDTH-1:0]             w1q2_reg;
    logic [P_WIDTH-1:0]             p_u3_reg;
    logic [P_WIDTH-1:0]             p_w1_reg;
    logic [P_WIDTH-1:0]             p_w2_reg;
    logic [P_WIDTH-1:0]             p_t3_reg;
    bce_pkg::coord_vec_t            coords2_reg;

    assign tq        = rnd_q(P_WIDTH'(tt1_reg));
    assign uq        = rnd_q(P_WIDTH'(uu1_reg));
    assign w1q       = rnd_q(P_WIDTH'(tu1_reg) << 1);
    assign tri_u2    = {2'b00, uq} + {1'b0, uq, 1'b0};
    assign tri_t2    = {2'b00, tq} + {1'b0, tq, 1'b0};
    assign p_u3_next = P_WIDTH'(uq) * P_WIDTH'(u1_reg);
    assign p_w1_next = P_WIDTH'(tri_u2) * P_WIDTH'(t1_reg);
    assign p_w2_next = P_WIDTH'(tri_t2) * P_WIDTH'(u1_reg);
    assign p_t3_next = P_WIDTH'(tq) * P_WIDTH'(t1_reg);

    // stage 3: per-mode weight selection
    logic signed [WX-1:0] ts;
    logic signed [WX-1:0] us;
    logic signed [WX-1:0] t2s;
    logic signed [WX-1:0] u2s;
    logic signed [WX-1:0] wx [bce_pkg::NUM_LANES];

    logic [bce_pkg::MODE_WIDTH-1:0] mode3_reg;
    bce_pkg::weight_vec_t           w3_reg;
    bce_pkg::coord_vec_t            coords3_reg;
    bce_pkg::weight_vec_t           w3_next;

    assign ts  = sx(t2_reg);
    assign us  = sx(u2_reg);
    assign t2s = sx(tq2_reg);
    assign u2s = sx(uq2_reg);

    always_comb
    begin
        for (int i = 0; i < bce_pkg::NUM_LANES; i++)
        begin
            wx[i] = '0;
        end
        case (mode2_reg)
            bce_pkg::MODE_LINEAR:
            begin
                wx[0] = us;
                wx[1] = ts;
            end
            bce_pkg::MODE_QUAD:
            begin
                wx[0] = u2s;
                wx[1] = sx(w1q2_reg);
                wx[2] = t2s;
            end
            bce_pkg::MODE_CUBIC:
            begin
                wx[0] = sx(rnd_q(p_u3_reg));
                wx[1] = sx(rnd_q(p_w1_reg));
                wx[2] = sx(rnd_q(p_w2_reg));
                wx[3] = sx(rnd_q(p_t3_reg));
            end
            bce_pkg::MODE_DERIV1:
            begin
                wx[0] = -((u2s <<< 1) + u2s);
                wx[1] = K3S - ((ts <<< 3) + (ts <<< 2)) + ((t2s <<< 3) + t2s);
                wx[2] = ((ts <<< 2) + (ts <<< 1)) - ((t2s <<< 3) + t2s);
                wx[3] = (t2s <<< 1) + t2s;
            end
            bce_pkg::MODE_DERIV2:
            begin
                wx[0] = K6S - ((ts <<< 2) + (ts <<< 1));
                wx[1] = ((ts <<< 4) + (ts <<< 1)) - K12S;
                wx[2] = K6S - ((ts <<< 4) + (ts <<< 1));
                wx[3] = (ts <<< 2) + (ts <<< 1);
            end
            default:
            begin
                for (int i = 0; i < bce_pkg::NUM_LANES; i++)
                begin
                    wx[i] = '0;
                end
            end
        endcase
        for (int i = 0; i < bce_pkg::NUM_LANES; i++)
        begin
            w3_next[i] = wx[i][bce_pkg::WEIGHT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            mode1_reg   <= req.req_type;
            t1_reg      <= t_sat;
            u1_reg      <= u_sat;
            tt1_reg     <= tt_next;
            uu1_reg     <= uu_next;
            tu1_reg     <= tu_next;
            coords1_reg <= {req.coord3, req.coord2, req.coord1, req.coord0};
        end
        if (ctl.en2)
        begin
            mode2_reg   <= mode1_reg;
            t2_reg      <= t1_reg;
            u2_reg      <= u1_reg;
            tq2_reg     <= tq;
            uq2_reg     <= uq;
            w1q2_reg    <= w1q;
            p_u3_reg    <= p_u3_next;
            p_w1_reg    <= p_w1_next;
            p_w2_reg    <= p_w2_next;
            p_t3_reg    <= p_t3_next;
            coords2_reg <= coords1_reg;
        end
        if (ctl.en3)
        begin
            mode3_reg   <= mode2_reg;
            w3_reg      <= w3_next;
            coords3_reg <= coords2_reg;
        end
    end

    assign weights = w3_reg;
    assign coords  = coords3_reg;

`ifndef SYNTHESIS
    // linear weights partition unity
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.v3 && mode3_reg == bce_pkg::MODE_LINEAR
        |-> (w3_reg[0] + w3_reg[1]) == bce_pkg::WEIGHT_WIDTH'(bce_pkg::ONE_Q)
            && w3_reg[2] == '0 && w3_reg[3] == '0)
        else $error("linear weights do not sum to one");

    // second-derivative weights sum to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.v3 && mode3_reg == bce_pkg::MODE_DERIV2
        |-> (w3_reg[0] + w3_reg[1] + w3_reg[2] + w3_reg[3]) == '0)
        else $error("second derivative weights do not cancel");
`endif

endmodule

FILE: hw/rtl/bce_lane.sv
// One multiply lane: weight times coordinate, registered, weight carried along.
// Depends on bce_pkg.
module bce_lane (
    input  logic              clk,
    input  logic              en,
    input  bce_pkg::weight_t  weight,
    input  bce_pkg::coord_t   coord,
    output bce_pkg::prod_t    prod,
    output bce_pkg::weight_t  weight_out
);

    bce_pkg::prod_t   prod_reg;
    bce_pkg::prod_t   prod_next;
    bce_pkg::weight_t weight_reg;

    assign prod_next = bce_pkg::PROD_WIDTH'(weight) * bce_pkg::PROD_WIDTH'(coord);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            weight_reg <= weight;
        end
    end

    assign prod       = prod_reg;
    assign weight_out = weight_reg;

endmodule

FILE: hw/rtl/bce_merge.sv
// Merge stage: sums the lane products, rounds half up and shifts down into the result beat.
// Depends on bce_pkg.
module bce_merge (
    input  logic                  clk,
    input  logic                  en,
    input  bce_pkg::prod_vec_t    prods,
    input  bce_pkg::weight_vec_t  weights,
    output bce_pkg::rsp_t         rsp
);

    logic signed [bce_pkg::ACC_WIDTH-1:0] acc;
    logic signed [bce_pkg::ACC_WIDTH-1:0] shifted;
    bce_pkg::rsp_t                        rsp_reg;
    bce_pkg::rsp_t                        rsp_next;

    always_comb
    begin
        acc = bce_pkg::ACC_WIDTH'(bce_pkg::HALF_Q);
        for (int i = 0; i < bce_pkg::NUM_LANES; i++)
        begin
            acc = acc + bce_pkg::ACC_WIDTH'(prods[i]);
        end
        // arithmetic shift gives the floor
        shifted              = acc >>> bce_pkg::FRAC_BITS;
        rsp_next.curve_value = shifted[bce_pkg::VALUE_WIDTH-1:0];
        rsp_next.weight0     = weights[0];
        rsp_next.weight1     = weights[1];
        rsp_next.weight2     = weights[2];
        rsp_next.weight3     = weights[3];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: hw/rtl/bernstein_curve_eval_unit.sv
// Top level of the Bernstein curve evaluation unit: handshake control and lane wiring.
// Depends on bce_pkg, bce_basis, bce_lane and bce_merge.
//
// Usage:
//   Request channel (req_valid, req_stall, req): one beat carries the mode, t in
//   unsigned Q1.15 and four signed control coordinates of one axis.
//   Response channel (rsp_valid, rsp_stall, rsp): one beat per request, in order,
//   with the rounded weighted sum and the four Q5.15 weights.
//   The beat passes five register stages: three basis stages (squares, cubic
//   products, weight selection), one stage of four parallel multiply lanes and the
//   merge stage that sums and rounds into the output register, where rsp_valid rises.
//   Throughput is one beat per cycle while rsp_stall is low; each stage holds one
//   beat and moves when the stage after it is empty or moving.
//   When the receiver stalls, beats pile up in the stages; req_stall rises only
//   once all five stages hold a beat, and the response beat holds steady.
//   Reset clears all stage valid bits; the unit accepts a beat in the first cycle
//   after reset is released. No state is kept between beats.
module bernstein_curve_eval_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bce_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bce_pkg::rsp_t  rsp
);

    localparam int NUM_STAGES = 5;

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] ready;

    bce_pkg::basis_ctl_t  basis_ctl;
    bce_pkg::weight_vec_t basis_w;
    bce_pkg::coord_vec_t  basis_c;
    bce_pkg::prod_vec_t   lane_p;
    bce_pkg::weight_vec_t lane_w;

    always_comb
    begin
        ready[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || !rsp_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !v_reg[k] || ready[k+1];
        end
        v_next[0] = ready[0] ? req_valid : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            v_next[k] = ready[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign req_stall = !ready[0];
    assign rsp_valid = v_reg[NUM_STAGES-1];

    assign basis_ctl.en1 = ready[0];
    assign basis_ctl.en2 = ready[1];
    assign basis_ctl.en3 = ready[2];
    assign basis_ctl.v3  = v_reg[2];

    bce_basis u_basis (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (basis_ctl),
        .req     (req),
        .weights (basis_w),
        .coords  (basis_c)
    );

    for (genvar i = 0; i < bce_pkg::NUM_LANES; i++)
    begin : g_lane
        bce_lane u_lane (
            .clk        (clk),
            .en         (ready[3]),
            .weight     (basis_w[i]),
            .coord      (basis_c[i]),
            .prod       (lane_p[i]),
            .weight_out (lane_w[i])
        );
    end

    bce_merge u_merge (
        .clk     (clk),
        .en      (ready[4]),
        .prods   (lane_p),
        .weights (lane_w),
        .rsp     (rsp)
    );

`ifndef SYNTHESIS
    // an accepted request lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> v_reg[0])
        else $error("accepted request beat lost at stage one");

    // input back-pressure only when every stage is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (&v_reg))
        else $error("request stalled with a free stage");

    // output drains when nothing is behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NUM_STAGES-1] && !rsp_stall && !v_reg[NUM_STAGES-2] |=> !rsp_valid)
        else $error("response beat repeated");
`endif

endmodule
